### hw/rtl/assert_macros.svh
// Assertion macros used by the timer top level.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define WBIT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define WBIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WBIT_ASSERT(lbl, clk, rst, prop, msg)
`define WBIT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/wbit_pkg.sv
// Types, codes and constants of the work/break interval timer.
// No dependencies; every other RTL source file but assert_macros.svh imports this package.
`default_nettype none
package wbit_pkg;

  localparam int unsigned MINUTES_W  = 11;
  localparam int unsigned SECONDS_W  = 16;
  localparam int unsigned TICK_W     = 12;
  localparam int unsigned ELAPSED_W  = 17;
  localparam int unsigned KIND_W     = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [5:0] SECS_PER_MIN = 6'd60;

  typedef logic [KIND_W-1:0] kind_t;

  // Item kinds
  localparam kind_t KIND_TICK      = 4'd0;
  localparam kind_t KIND_ENABLE    = 4'd1;
  localparam kind_t KIND_DISABLE   = 4'd2;
  localparam kind_t KIND_PAUSE     = 4'd3;
  localparam kind_t KIND_UNPAUSE   = 4'd4;
  localparam kind_t KIND_BREAK_NOW = 4'd5;
  localparam kind_t KIND_RESTART   = 4'd6;
  localparam kind_t KIND_UNLOCK    = 4'd7;
  localparam kind_t KIND_RESUME    = 4'd8;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Configuration register indexes
  localparam reg_idx_t REG_WORK_MINUTES  = 2'd0;
  localparam reg_idx_t REG_BREAK_SECONDS = 2'd1;
  localparam reg_idx_t REG_WARN_SECONDS  = 2'd2;

  localparam logic [MINUTES_W-1:0] WORK_MINUTES_RST  = 11'd60;
  localparam logic [SECONDS_W-1:0] BREAK_SECONDS_RST = 16'd300;
  localparam logic [SECONDS_W-1:0] WARN_SECONDS_RST  = 16'd60;

  typedef struct packed {
    logic [MINUTES_W-1:0] work_minutes;
    logic [SECONDS_W-1:0] break_seconds;
    logic [SECONDS_W-1:0] warn_seconds;
  } cfg_t;

  typedef struct packed {
    logic                 is_enabled;
    logic                 in_break;
    logic                 is_paused;
    logic                 waiting_resume;
    logic [ELAPSED_W-1:0] work_left;
    logic [SECONDS_W-1:0] break_left;
    logic                 break_started;
    logic                 break_ended;
    logic                 warning_fired;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/wbit_if.sv
// Channel interfaces of the timer: item input, result output, register writes.
// Depends on wbit_pkg.
`default_nettype none
interface wbit_item_if import wbit_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [TICK_W-1:0]    tick_seconds;

  modport source (output valid, kind, tick_seconds, input ready);
  modport sink   (input valid, kind, tick_seconds, output ready);
endinterface

interface wbit_result_if import wbit_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 is_enabled;
  logic                 in_break;
  logic                 is_paused;
  logic                 waiting_resume;
  logic [ELAPSED_W-1:0] work_left;
  logic [SECONDS_W-1:0] break_left;
  logic                 break_started;
  logic                 break_ended;
  logic                 warning_fired;

  modport source (output valid, is_enabled, in_break, is_paused, waiting_resume,
                  work_left, break_left, break_started, break_ended, warning_fired,
                  input ready);
  modport sink   (input valid, is_enabled, in_break, is_paused, waiting_resume,
                  work_left, break_left, break_started, break_ended, warning_fired,
                  output ready);
endinterface

interface wbit_cfg_if import wbit_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [SECONDS_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/wbit_cfg_regs.sv
// Configuration registers of the timer, written through the register channel.
// Depends on wbit_pkg and wbit_if.
`default_nettype none
module wbit_cfg_regs import wbit_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  wbit_cfg_if.sink   cfg,
  output cfg_t       regs
);

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.work_minutes  <= WORK_MINUTES_RST;
      regs_q.break_seconds <= BREAK_SECONDS_RST;
      regs_q.warn_seconds  <= WARN_SECONDS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WORK_MINUTES:  regs_q.work_minutes  <= cfg.data[MINUTES_W-1:0];
        REG_BREAK_SECONDS: regs_q.break_seconds <= cfg.data;
        REG_WARN_SECONDS:  regs_q.warn_seconds  <= cfg.data;
        default: ;  // drop writes past the last register
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wbit_core.sv
// Timer state and its single-pass update for one item.
// Depends on wbit_pkg.
`default_nettype none
module wbit_core import wbit_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [TICK_W-1:0] tick_seconds,
  input  wire cfg_t              regs,
  output res_t                   res
);

  logic                 enabled, brk, paused, await_resume, warned;
  logic [ELAPSED_W-1:0] elapsed;
  logic [SECONDS_W-1:0] break_length;
  logic [ELAPSED_W-1:0] work_remaining;
  logic [SECONDS_W-1:0] break_remaining;

  logic                 enabled_next, brk_next, paused_next, await_next, warned_next;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [SECONDS_W-1:0] break_length_next;
  logic [ELAPSED_W-1:0] work_remaining_next;
  logic [SECONDS_W-1:0] break_remaining_next;
  logic                 ev_start, ev_end, ev_warn;

  logic [ELAPSED_W-1:0] work_len;
  logic [TICK_W-1:0]    secs_eff;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 work_pos, brk_pos, warn_hit, do_adv;
  logic [ELAPSED_W-1:0] work_diff;
  logic [SECONDS_W-1:0] brk_diff;

  assign work_len    = ELAPSED_W'(regs.work_minutes) * ELAPSED_W'(SECS_PER_MIN);
  assign secs_eff    = (kind == KIND_TICK) ? tick_seconds : '0;
  assign elapsed_sum = {1'b0, elapsed} + (ELAPSED_W + 1)'(secs_eff);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

  assign work_pos  = work_len > elapsed_sat;
  assign work_diff = work_len - elapsed_sat;
  assign brk_pos   = ELAPSED_W'(break_length) > elapsed_sat;
  assign brk_diff  = break_length - elapsed_sat[SECONDS_W-1:0];
  assign warn_hit  = !warned && (regs.warn_seconds != '0)
                   && (ELAPSED_W'(regs.warn_seconds) < work_len)
                   && (work_diff <= ELAPSED_W'(regs.warn_seconds));

  // Countdown advances on a running tick, or on unpause as a zero-second tick
  assign do_adv = ((kind == KIND_TICK) && enabled && !paused && !await_resume)
                || ((kind == KIND_UNPAUSE) && paused && enabled && !brk);

  always_comb begin
    enabled_next         = enabled;
    brk_next             = brk;
    paused_next          = paused;
    await_next           = await_resume;
    warned_next          = warned;
    elapsed_next         = elapsed;
    break_length_next    = break_length;
    work_remaining_next  = work_remaining;
    break_remaining_next = break_remaining;
    ev_start             = 1'b0;
    ev_end               = 1'b0;
    ev_warn              = 1'b0;

    unique case (kind)
      KIND_ENABLE: begin
        if (!enabled) begin
          enabled_next         = 1'b1;
          brk_next             = 1'b0;
          warned_next          = 1'b0;
          paused_next          = 1'b0;
          elapsed_next         = '0;
          work_remaining_next  = work_len;
          break_remaining_next = '0;
        end
      end
      KIND_DISABLE: begin
        if (enabled && !brk) begin
          enabled_next         = 1'b0;
          paused_next          = 1'b0;
          work_remaining_next  = '0;
          break_remaining_next = '0;
        end
      end
      KIND_PAUSE: begin
        if (!paused && enabled && !brk) paused_next = 1'b1;
      end
      KIND_UNPAUSE: begin
        if (do_adv) paused_next = 1'b0;
      end
      KIND_RESTART: begin
        if (enabled && !brk) begin
          brk_next             = 1'b0;
          warned_next          = 1'b0;
          paused_next          = 1'b0;
          elapsed_next         = '0;
          work_remaining_next  = work_len;
          break_remaining_next = '0;
        end
      end
      KIND_UNLOCK, KIND_RESUME: begin
        if ((kind == KIND_UNLOCK) ? brk : await_resume) begin
          brk_next             = 1'b0;
          await_next           = 1'b0;
          ev_end               = 1'b1;
          warned_next          = 1'b0;
          paused_next          = 1'b0;
          elapsed_next         = '0;
          work_remaining_next  = work_len;
          break_remaining_next = '0;
        end
      end
      default: ;  // tick and break now handled below, unknown kinds ignored
    endcase

    if (do_adv) begin
      elapsed_next = elapsed_sat;
      if (brk) begin
        break_remaining_next = brk_pos ? brk_diff : '0;
        if (!brk_pos) await_next = 1'b1;
      end else begin
        work_remaining_next = work_pos ? work_diff : '0;
        if (work_pos && warn_hit) begin
          warned_next = 1'b1;
          ev_warn     = 1'b1;
        end
      end
    end

    // Break begins on an expired work countdown or on break now
    if ((do_adv && !brk && !work_pos)
        || ((kind == KIND_BREAK_NOW) && enabled && !brk)) begin
      brk_next             = 1'b1;
      await_next           = 1'b0;
      paused_next          = 1'b0;
      elapsed_next         = '0;
      break_length_next    = regs.break_seconds;
      work_remaining_next  = '0;
      break_remaining_next = regs.break_seconds;
      ev_start             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      brk             <= 1'b0;
      paused          <= 1'b0;
      await_resume    <= 1'b0;
      warned          <= 1'b0;
      elapsed         <= '0;
      break_length    <= '0;
      work_remaining  <= '0;
      break_remaining <= '0;
    end else if (fire) begin
      enabled         <= enabled_next;
      brk             <= brk_next;
      paused          <= paused_next;
      await_resume    <= await_next;
      warned          <= warned_next;
      elapsed         <= elapsed_next;
      break_length    <= break_length_next;
      work_remaining  <= work_remaining_next;
      break_remaining <= break_remaining_next;
    end
  end

  always_comb begin
    res.is_enabled     = enabled_next;
    res.in_break       = brk_next;
    res.is_paused      = paused_next;
    res.waiting_resume = await_next;
    res.work_left      = work_remaining_next;
    res.break_left     = break_remaining_next;
    res.break_started  = ev_start;
    res.break_ended    = ev_end;
    res.warning_fired  = ev_warn;
  end

endmodule
`default_nettype wire

### hw/rtl/work_break_interval_timer_unit.sv
// Top level of the work/break interval timer: input register, update, result register.
// Depends on wbit_pkg, wbit_if, wbit_cfg_regs, wbit_core and assert_macros.svh.
//
//   channel  dir  handshake     word
//   item     in   valid/ready   kind, tick_seconds
//   result   out  valid/ready   status flags, work_left, break_left, event flags
//   cfg      in   valid/ready   index, data (register write, always ready)
//
// Throughput: one item per cycle while the result side takes each word.
// The item waits in the input register, then the state update and the
// result register load happen in the same cycle.
// Stalls: when result is held, an empty input register still takes one more word.
// Reset (rst, synchronous) empties both registers and clears all timer state.
// Register writes take effect on the next item; write them only while idle.
`default_nettype none
`include "assert_macros.svh"
module work_break_interval_timer_unit import wbit_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  wbit_item_if.sink    item,
  wbit_result_if.source result,
  wbit_cfg_if.sink     cfg
);

  cfg_t              regs;
  res_t              res_comb;
  res_t              res_q;
  logic              in_valid;
  logic [KIND_W-1:0] in_kind;
  logic [TICK_W-1:0] in_secs;
  logic              out_valid;
  logic              advance;
  logic              fire;
  logic              accept;

  wbit_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Result register is free when empty or being taken this cycle
  assign advance    = !out_valid || result.ready;
  assign fire       = in_valid && advance;
  assign item.ready = !in_valid || advance;
  assign accept     = item.valid && item.ready;

  wbit_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .kind         (in_kind),
    .tick_seconds (in_secs),
    .regs         (regs),
    .res          (res_comb)
  );

  // Input register: hold the word until the update stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind <= item.kind;
      in_secs <= item.tick_seconds;
    end
  end

  // Result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign result.valid          = out_valid;
  assign result.is_enabled     = res_q.is_enabled;
  assign result.in_break       = res_q.in_break;
  assign result.is_paused      = res_q.is_paused;
  assign result.waiting_resume = res_q.waiting_resume;
  assign result.work_left      = res_q.work_left;
  assign result.break_left     = res_q.break_left;
  assign result.break_started  = res_q.break_started;
  assign result.break_ended    = res_q.break_ended;
  assign result.warning_fired  = res_q.warning_fired;

  `WBIT_ASSERT(a_fire_gives_result, clk, rst, fire |=> out_valid, "update lost its result")
  `WBIT_ASSERT(a_break_needs_enable, clk, rst, out_valid |-> (!res_q.in_break || res_q.is_enabled), "break while disabled")
  `WBIT_ASSERT(a_wait_only_in_break, clk, rst, out_valid |-> (!res_q.waiting_resume || res_q.in_break), "waiting outside a break")
  `WBIT_ASSERT(a_events_exclusive, clk, rst, out_valid |-> $onehot0({res_q.break_started, res_q.break_ended, res_q.warning_fired}), "two events on one word")

endmodule
`default_nettype wire

### bench/work_break_interval_timer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for work_break_interval_timer_unit: a table of directed words, then
// random phases under several register settings. Depends on wbit_pkg and the wbit_if channels.
module work_break_interval_timer_unit_tb;
  import wbit_pkg::*;

  // Kinds outside the decoded range; the block must ignore them and still report status.
  localparam kind_t KIND_UNUSED_LO = 4'd9;
  localparam kind_t KIND_UNUSED_HI = 4'd15;

  localparam int ELAPSED_MAX = (1 << ELAPSED_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_REPORTS = 30;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 140;

  // Receiver back-pressure styles, one per phase.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_SPARSE
  } ready_mode_t;

  // One directed word; when pinned, the expected status is typed in the table.
  typedef struct packed {
    kind_t               kind;
    logic [TICK_W-1:0]   secs;
    logic                pinned;
    res_t                want;
  } plan_row_t;

  localparam res_t IDLE_STATUS = '0;
  localparam int PLAN_LEN = 26;

  // Reset registers: 60 minutes of work (3600 s), 300 s break, warning at 60 s left.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // everything but enable is dead while disabled
    '{KIND_TICK,      12'd4095, 1'b1, IDLE_STATUS},
    '{KIND_PAUSE,     12'd0,    1'b1, IDLE_STATUS},
    '{KIND_BREAK_NOW, 12'd0,    1'b1, IDLE_STATUS},
    '{KIND_UNLOCK,    12'd0,    1'b1, IDLE_STATUS},
    '{KIND_RESUME,    12'd0,    1'b1, IDLE_STATUS},
    '{KIND_UNUSED_HI, 12'd4095, 1'b1, IDLE_STATUS},
    '{KIND_ENABLE,    12'd0,    1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 17'd3600, 16'd0, 1'b0, 1'b0, 1'b0}},
    // count down into the warning window, then pause and unpause
    '{KIND_TICK,      12'd0,    1'b0, IDLE_STATUS},
    '{KIND_TICK,      12'd3000, 1'b0, IDLE_STATUS},
    '{KIND_TICK,      12'd540,  1'b0, IDLE_STATUS},
    '{KIND_PAUSE,     12'd0,    1'b0, IDLE_STATUS},
    '{KIND_TICK,      12'd100,  1'b0, IDLE_STATUS},
    '{KIND_UNPAUSE,   12'd0,    1'b0, IDLE_STATUS},
    // overrun the work phase: break starts with the latched 300 s
    '{KIND_TICK,      12'd4095, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 16'd300, 1'b1, 1'b0, 1'b0}},
    // refused during a break
    '{KIND_DISABLE,   12'd0,    1'b0, IDLE_STATUS},
    '{KIND_PAUSE,     12'd0,    1'b0, IDLE_STATUS},
    '{KIND_RESTART,   12'd0,    1'b0, IDLE_STATUS},
    '{KIND_BREAK_NOW, 12'd0,    1'b0, IDLE_STATUS},
    // run the break out, ignore ticks while waiting, then resume
    '{KIND_TICK,      12'd300,  1'b0, IDLE_STATUS},
    '{KIND_TICK,      12'd7,    1'b0, IDLE_STATUS},
    '{KIND_RESUME,    12'd0,    1'b0, IDLE_STATUS},
    // forced break cut short by unlock, restart, then disable while paused
    '{KIND_BREAK_NOW, 12'd0,    1'b0, IDLE_STATUS},
    '{KIND_UNLOCK,    12'd0,    1'b0, IDLE_STATUS},
    '{KIND_RESTART,   12'd0,    1'b0, IDLE_STATUS},
    '{KIND_PAUSE,     12'd0,    1'b0, IDLE_STATUS},
    '{KIND_DISABLE,   12'd0,    1'b0, IDLE_STATUS}
  };

  logic clk;
  logic rst;

  wbit_item_if   item_ch ();
  wbit_result_if res_ch ();
  wbit_cfg_if    cfg_ch ();

  work_break_interval_timer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the timer: registers and state as seen by the accepted words.
  logic [MINUTES_W-1:0] cfg_work_min;
  logic [SECONDS_W-1:0] cfg_break_sec;
  logic [SECONDS_W-1:0] cfg_warn_sec;
  logic                 running, on_break, paused, awaiting, warned;
  int                   elapsed_s;
  logic [SECONDS_W-1:0] brk_len;
  logic [ELAPSED_W-1:0] work_rem;
  logic [SECONDS_W-1:0] brk_rem;
  logic                 ev_start, ev_end, ev_warn;

  res_t status_due [$];   // expected status words, oldest first

  // Pinned expectation travels with the offered word, so it changes on the same edges.
  logic        pin_on;
  res_t        pin_word;

  int          words_sent;
  int          words_checked;
  int          errors;
  int          cycle_count;
  int          burst_left;
  bit          steady;
  bit          big_ticks;
  ready_mode_t ready_mode;
  int          hold_asks;
  int          hold_seen;
  int          hold_left;

  always #5 clk = ~clk;

  function automatic int work_secs();
    return int'(cfg_work_min) * int'(SECS_PER_MIN);
  endfunction

  function automatic void open_work();
    on_break  = 1'b0;
    warned    = 1'b0;
    paused    = 1'b0;
    elapsed_s = 0;
    work_rem  = ELAPSED_W'(work_secs());
    brk_rem   = '0;
  endfunction

  function automatic void open_break();
    on_break  = 1'b1;
    awaiting  = 1'b0;
    paused    = 1'b0;
    elapsed_s = 0;
    brk_len   = cfg_break_sec;
    work_rem  = '0;
    brk_rem   = cfg_break_sec;
    ev_start  = 1'b1;
  endfunction

  // Advance the running countdown by secs; zero re-evaluates without advancing.
  function automatic void count_down(int secs);
    int remain;
    int wlen;
    wlen = work_secs();
    elapsed_s = elapsed_s + secs;
    if (elapsed_s > ELAPSED_MAX) elapsed_s = ELAPSED_MAX;
    if (on_break) begin
      remain  = int'(brk_len) - elapsed_s;
      brk_rem = (remain > 0) ? remain[SECONDS_W-1:0] : '0;
      if (remain <= 0) awaiting = 1'b1;
    end else begin
      remain   = wlen - elapsed_s;
      work_rem = (remain > 0) ? remain[ELAPSED_W-1:0] : '0;
      if (remain <= 0) begin
        open_break();
      end else if (!warned && cfg_warn_sec != 0 && int'(cfg_warn_sec) < wlen &&
                   remain <= int'(cfg_warn_sec)) begin
        warned  = 1'b1;
        ev_warn = 1'b1;
      end
    end
  endfunction

  // Apply one accepted word to the shadow state and return the status it reports.
  function automatic res_t next_status(kind_t kind, logic [TICK_W-1:0] secs);
    logic closing;
    ev_start = 1'b0;
    ev_end   = 1'b0;
    ev_warn  = 1'b0;
    closing  = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (running && !paused && !awaiting) count_down(int'(secs));
      end
      KIND_ENABLE: begin
        if (!running) begin
          running = 1'b1;
          open_work();
        end
      end
      KIND_DISABLE: begin
        if (running && !on_break) begin
          running  = 1'b0;
          paused   = 1'b0;
          work_rem = '0;
          brk_rem  = '0;
        end
      end
      KIND_PAUSE: begin
        if (!paused && running && !on_break) paused = 1'b1;
      end
      KIND_UNPAUSE: begin
        // paused time is not counted: re-evaluate with zero seconds
        if (paused && running && !on_break) begin
          paused = 1'b0;
          count_down(0);
        end
      end
      KIND_BREAK_NOW: begin
        if (running && !on_break) open_break();
      end
      KIND_RESTART: begin
        if (running && !on_break) open_work();
      end
      KIND_UNLOCK: closing = on_break;
      KIND_RESUME: closing = awaiting;
      default: ;
    endcase
    if (closing) begin
      awaiting = 1'b0;
      ev_end   = 1'b1;
      open_work();
    end
    return '{running, on_break, paused, awaiting, work_rem, brk_rem, ev_start, ev_end, ev_warn};
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] word %0d: %s", $realtime, words_checked, msg);
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input kind_t kind, input logic [TICK_W-1:0] secs,
                           input logic pin, input res_t want);
    item_ch.kind         <= kind;
    item_ch.tick_seconds <= secs;
    item_ch.valid        <= 1'b1;
    pin_on               <= pin;
    pin_word             <= want;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
  endtask

  // Sender pacing: bursts of random length separated by random gaps, none when steady.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every accepted word has come back.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays high across the writes.
  task automatic write_regs(input logic [SECONDS_W-1:0] wm, input logic [SECONDS_W-1:0] bs,
                            input logic [SECONDS_W-1:0] ws);
    logic [SECONDS_W-1:0] vals [3];
    reg_idx_t             idxs [3];
    vals = '{wm, bs, ws};
    idxs = '{REG_WORK_MINUTES, REG_BREAK_SECONDS, REG_WARN_SECONDS};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.index <= idxs[i];
      cfg_ch.data  <= vals[i];
      cfg_ch.valid <= 1'b1;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Monitor: track register writes, predict each accepted word, check each result word.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t predicted;
    if (rst) begin
      cfg_work_min  = WORK_MINUTES_RST;
      cfg_break_sec = BREAK_SECONDS_RST;
      cfg_warn_sec  = WARN_SECONDS_RST;
      running = 1'b0; on_break = 1'b0; paused = 1'b0; awaiting = 1'b0; warned = 1'b0;
      elapsed_s = 0;
      brk_len   = '0;
      work_rem  = '0;
      brk_rem   = '0;
      status_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WORK_MINUTES:  cfg_work_min  = cfg_ch.data[MINUTES_W-1:0];
          REG_BREAK_SECONDS: cfg_break_sec = cfg_ch.data;
          REG_WARN_SECONDS:  cfg_warn_sec  = cfg_ch.data;
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        // advance the shadow state even when the table pins the answer
        predicted = next_status(item_ch.kind, item_ch.tick_seconds);
        status_due.push_back(pin_on ? pin_word : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.is_enabled, res_ch.in_break, res_ch.is_paused, res_ch.waiting_resume,
                res_ch.work_left, res_ch.break_left, res_ch.break_started,
                res_ch.break_ended, res_ch.warning_fired};
        if (status_due.size() == 0) begin
          report("result word with nothing pending");
        end else begin
          want = status_due.pop_front();
          if (got.is_enabled !== want.is_enabled)
            report($sformatf("is_enabled %0b, expected %0b", got.is_enabled, want.is_enabled));
          if (got.in_break !== want.in_break)
            report($sformatf("in_break %0b, expected %0b", got.in_break, want.in_break));
          if (got.is_paused !== want.is_paused)
            report($sformatf("is_paused %0b, expected %0b", got.is_paused, want.is_paused));
          if (got.waiting_resume !== want.waiting_resume)
            report($sformatf("waiting_resume %0b, expected %0b",
                             got.waiting_resume, want.waiting_resume));
          if (got.work_left !== want.work_left)
            report($sformatf("work_left %0d, expected %0d", got.work_left, want.work_left));
          if (got.break_left !== want.break_left)
            report($sformatf("break_left %0d, expected %0d", got.break_left, want.break_left));
          if (got.break_started !== want.break_started)
            report($sformatf("break_started %0b, expected %0b",
                             got.break_started, want.break_started));
          if (got.break_ended !== want.break_ended)
            report($sformatf("break_ended %0b, expected %0b",
                             got.break_ended, want.break_ended));
          if (got.warning_fired !== want.warning_fired)
            report($sformatf("warning_fired %0b, expected %0b",
                             got.warning_fired, want.warning_fired));
        end
        words_checked++;
      end
    end
  end

  // Receiver: a long hold when asked, otherwise the back-pressure style of the phase.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS:  res_ch.ready <= 1'b1;
        READY_RANDOM:  res_ch.ready <= ($urandom_range(0, 2) != 0);
        READY_PATTERN: res_ch.ready <= ((cycle_count % 8) >= 3);
        default:       res_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [SECONDS_W-1:0] wm, bs, ws;
    kind_t                kind;
    logic [TICK_W-1:0]    secs;
    int                   pick;

    // Drive every input to a known value before the first edge.
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_TICK;
    item_ch.tick_seconds = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_WORK_MINUTES;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;
    pin_on        = 1'b0;
    pin_word      = IDLE_STATUS;
    words_sent    = 0;
    words_checked = 0;
    errors        = 0;
    cycle_count   = 0;
    burst_left    = 0;
    steady        = 1'b1;
    big_ticks     = 1'b0;
    ready_mode    = READY_ALWAYS;
    hold_asks     = 0;
    hold_seen     = 0;
    hold_left     = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset register values.
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_word(PLAN[i].kind, PLAN[i].secs, PLAN[i].pinned, PLAN[i].want);
      pace();
    end
    wait_idle();

    // Random phases; registers change only once the block has drained.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin  // shortest work, no break, no warning; no idling on either side
          wm = 16'd1; bs = 16'd0; ws = 16'd0;
          ready_mode <= READY_ALWAYS; steady = 1'b1; big_ticks = 1'b0;
        end
        1: begin  // break and warning registers at their top, work at 1440 minutes
          wm = 16'd1440; bs = 16'd65535; ws = 16'd65535;
          ready_mode <= READY_RANDOM; steady = 1'b0; big_ticks = 1'b1;
        end
        2: begin  // threshold equal to the work length: warning never fires
          wm = 16'd1; bs = 16'd5; ws = 16'd60;
          ready_mode <= READY_PATTERN; steady = 1'b0; big_ticks = 1'b0;
        end
        3: begin  // threshold just below the work length
          wm = 16'd1; bs = 16'd30; ws = 16'd59;
          ready_mode <= READY_SPARSE; steady = 1'b0; big_ticks = 1'b0;
        end
        4: begin
          wm = 16'($urandom_range(1, 5));
          bs = 16'($urandom_range(0, 200));
          ws = 16'($urandom_range(0, 400));
          ready_mode <= READY_RANDOM; steady = 1'b0; big_ticks = 1'b0;
        end
        default: begin
          wm = 16'($urandom_range(2, 30));
          bs = 16'($urandom_range(0, 65535));
          ws = 16'($urandom_range(0, 65535));
          ready_mode <= READY_PATTERN; steady = 1'b0; big_ticks = 1'b1;
        end
      endcase
      write_regs(wm, bs, ws);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // stall the result side for a long stretch while words keep coming
        if (p == 2 && n == PHASE_WORDS / 2) hold_asks <= hold_asks + 1;
        // hold the sender until everything in flight has come back
        if (p == 3 && n == PHASE_WORDS / 2) wait_idle();

        pick = $urandom_range(0, 99);
        if      (pick < 50) kind = KIND_TICK;
        else if (pick < 58) kind = KIND_ENABLE;
        else if (pick < 62) kind = KIND_DISABLE;
        else if (pick < 67) kind = KIND_PAUSE;
        else if (pick < 73) kind = KIND_UNPAUSE;
        else if (pick < 78) kind = KIND_BREAK_NOW;
        else if (pick < 82) kind = KIND_RESTART;
        else if (pick < 88) kind = KIND_UNLOCK;
        else if (pick < 96) kind = KIND_RESUME;
        else kind = kind_t'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));

        // mostly short ticks so phases roll over often, some across the full range (most with big_ticks)
        pick = $urandom_range(0, 99);
        if (big_ticks && pick < 50) secs = TICK_W'($urandom_range(0, 4095));
        else if (pick < 70)         secs = TICK_W'($urandom_range(0, 63));
        else if (pick < 90)         secs = TICK_W'($urandom_range(0, 600));
        else                        secs = TICK_W'($urandom_range(0, 4095));

        send_word(kind, secs, 1'b0, IDLE_STATUS);
        pace();
      end
      wait_idle();
    end

    // Let any stray result word surface before the verdict.
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### work_break_interval_timer_unit.f
+incdir+hw/rtl
hw/rtl/wbit_pkg.sv
hw/rtl/wbit_if.sv
hw/rtl/wbit_cfg_regs.sv
hw/rtl/wbit_core.sv
hw/rtl/work_break_interval_timer_unit.sv
bench/work_break_interval_timer_unit_tb.sv
